/* src/mstt_pkg.sv */
// Package for the host status and timeout tracker.
// Holds the field widths, codes, config/state/item/result structs.
// No dependencies.
package mstt_pkg;

    localparam int TIMER_W = 20;
    localparam int STEP_W  = 16;
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int RES_W   = 2;
    localparam int HS_W    = 3;
    localparam int IDX_W   = 2;

    // item kinds
    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_CMD  = 2'd2;

    // command outcome
    localparam logic [RES_W-1:0] RES_OK      = 2'd0;
    localparam logic [RES_W-1:0] RES_LEN_ERR = 2'd1;
    localparam logic [RES_W-1:0] RES_UNKNOWN = 2'd2;

    // host status codes
    localparam logic [HS_W-1:0] HS_UNKNOWN     = 3'd0;
    localparam logic [HS_W-1:0] HS_CONFIGURING = 3'd4;
    localparam logic [HS_W-1:0] HS_UPDATING    = 3'd5;

    // a command carries exactly one payload byte
    localparam logic [BYTE_W-1:0] CMD_LEN      = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_SET_MAX  = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_UPDATE   = 8'd5;

    // register indexes
    localparam logic [IDX_W-1:0] REG_UPDATE_TIMEOUT = 2'd0;
    localparam logic [IDX_W-1:0] REG_STARTUP_TIME   = 2'd1;
    localparam logic [IDX_W-1:0] REG_COLD_START     = 2'd2;
    localparam logic [IDX_W-1:0] REG_TICK_STEP      = 2'd3;

    // register reset values
    localparam logic [TIMER_W-1:0] UPDATE_TIMEOUT_RST = 20'd30000;
    localparam logic [TIMER_W-1:0] STARTUP_TIME_RST   = 20'd10000;
    localparam logic [STEP_W-1:0]  TICK_STEP_RST      = 16'd100;

    typedef struct packed {
        logic [TIMER_W-1:0] update_timeout;
        logic [TIMER_W-1:0] startup_time;
        logic               cold_start;
        logic [STEP_W-1:0]  tick_step;
    } cfg_t;

    typedef struct packed {
        logic [TIMER_W-1:0] startup_left;
        logic [TIMER_W-1:0] update_left;
        logic [HS_W-1:0]    status;
        logic               observer;
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] payload_count;
        logic [BYTE_W-1:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic [RES_W-1:0] cmd_status;
        logic [HS_W-1:0]  host_status;
        logic             observer_on;
        logic             status_written;
    } result_t;

endpackage

/* src/mstt_if.sv */
// Channel interfaces of the host status tracker: item in, result out, config write.
// Depends on mstt_pkg for field widths.
interface mstt_req_if;
    logic                          valid;
    logic                          ready;
    logic [mstt_pkg::OP_W-1:0]     opcode;
    logic [mstt_pkg::BYTE_W-1:0]   payload_count;
    logic [mstt_pkg::BYTE_W-1:0]   payload_byte;

    modport source (output valid, opcode, payload_count, payload_byte, input ready);
    modport sink   (input valid, opcode, payload_count, payload_byte, output ready);
endinterface

interface mstt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mstt_pkg::RES_W-1:0]    cmd_status;
    logic [mstt_pkg::HS_W-1:0]     host_status;
    logic                          observer_on;
    logic                          status_written;

    modport source (output valid, cmd_status, host_status, observer_on, status_written,
                    input ready);
    modport sink   (input valid, cmd_status, host_status, observer_on, status_written,
                    output ready);
endinterface

interface mstt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mstt_pkg::IDX_W-1:0]    index;
    logic [mstt_pkg::TIMER_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/mstt_core.sv */
// Next-state and result logic for one item of the host status tracker.
// Purely combinational; depends on mstt_pkg.
module mstt_core (
    input  mstt_pkg::cfg_t    cfg,
    input  mstt_pkg::state_t  state,
    input  mstt_pkg::item_t   item,
    output mstt_pkg::state_t  state_next,
    output mstt_pkg::result_t res
);
    import mstt_pkg::*;

    logic [TIMER_W-1:0] step;
    logic               startup_exp;
    logic               update_exp;
    logic [TIMER_W-1:0] startup_dec;
    logic [TIMER_W-1:0] update_dec;

    assign step = TIMER_W'(cfg.tick_step);

    // countdown: idle at zero, expire when at most one step is left
    assign startup_exp = (state.startup_left != '0) && (state.startup_left <= step);
    assign update_exp  = (state.update_left != '0) && (state.update_left <= step);
    assign startup_dec = (state.startup_left <= step) ? '0 : state.startup_left - step;
    assign update_dec  = (state.update_left <= step) ? '0 : state.update_left - step;

    always_comb
    begin
        state_next         = state;
        res.cmd_status     = RES_OK;
        res.status_written = 1'b0;
        unique case (item.opcode)
            OP_INIT:
            begin
                if (cfg.cold_start)
                begin
                    state_next.startup_left = cfg.startup_time;
                end
            end
            OP_TICK:
            begin
                state_next.startup_left = startup_dec;
                if (startup_exp)
                begin
                    state_next.update_left = cfg.update_timeout;
                    state_next.status      = HS_UPDATING;
                    state_next.observer    = 1'b0;
                    res.status_written     = 1'b1;
                end
                else
                begin
                    state_next.update_left = update_dec;
                    if (update_exp)
                    begin
                        state_next.status  = HS_UNKNOWN;
                        res.status_written = 1'b1;
                    end
                end
            end
            OP_CMD:
            begin
                priority if (item.payload_count != CMD_LEN)
                begin
                    res.cmd_status = RES_LEN_ERR;
                end
                else if (item.payload_byte <= CMD_SET_MAX)
                begin
                    state_next.startup_left = '0;
                    state_next.update_left  = '0;
                    state_next.status       = item.payload_byte[HS_W-1:0];
                    state_next.observer     = (item.payload_byte != '0);
                    res.status_written      = 1'b1;
                end
                else if (item.payload_byte == CMD_UPDATE)
                begin
                    state_next.update_left = cfg.update_timeout;
                    state_next.status      = HS_UPDATING;
                    state_next.observer    = 1'b0;
                    res.status_written     = 1'b1;
                end
                else
                begin
                    res.cmd_status = RES_UNKNOWN;
                end
            end
            default:
            begin
                // unused opcode: no change, ok
            end
        endcase
        res.host_status = state_next.status;
        res.observer_on = state_next.observer;
    end

endmodule

/* src/master_status_timeout_tracker_top.sv */
// Host status and timeout tracker, top level.
// An accepted item passes through the input register and then the result register.
// One item per cycle while the result side does not stall; the state registers update in the cycle an item
// moves from the input register into the result register.
// Reset (rst_n low, asynchronous): status unknown, observer off, timers zero,
// registers at update_timeout 30000, startup_time 10000, cold_start 0, tick_step 100.
module master_status_timeout_tracker_top (
    input  logic       clk,
    input  logic       rst_n,
    mstt_req_if.sink   req,
    mstt_rsp_if.source rsp,
    mstt_cfg_if.sink   cfg
);
    import mstt_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // tracker state
    state_t  state_reg;
    state_t  state_next;

    // input register
    logic    item_valid_reg;
    item_t   item_reg;

    // result register
    logic    rsp_valid_reg;
    result_t rsp_reg;
    result_t rsp_next;

    logic    advance;

    // Move the held item into the result register when the result slot is
    // free or is being emptied this cycle; the input register refills at once.
    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Config writes land directly; the user must write only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_timeout <= UPDATE_TIMEOUT_RST;
            cfg_reg.startup_time   <= STARTUP_TIME_RST;
            cfg_reg.cold_start     <= 1'b0;
            cfg_reg.tick_step      <= TICK_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_UPDATE_TIMEOUT: cfg_reg.update_timeout <= cfg.data;
                REG_STARTUP_TIME:   cfg_reg.startup_time   <= cfg.data;
                REG_COLD_START:     cfg_reg.cold_start     <= cfg.data[0];
                REG_TICK_STEP:      cfg_reg.tick_step      <= cfg.data[STEP_W-1:0];
                default:            cfg_reg.cold_start     <= cfg_reg.cold_start;
            endcase
        end
    end

    // Capture an accepted item; hold it while the result side stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.opcode        <= req.opcode;
            item_reg.payload_count <= req.payload_count;
            item_reg.payload_byte  <= req.payload_byte;
        end
    end

    // One pass of countdown and command decode against the current state.
    mstt_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (rsp_next)
    );

    // Commit state only when the item's result is taken into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.startup_left <= '0;
            state_reg.update_left  <= '0;
            state_reg.status       <= HS_UNKNOWN;
            state_reg.observer     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: fill on advance, drop when taken with nothing behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.cmd_status     = rsp_reg.cmd_status;
    assign rsp.host_status    = rsp_reg.host_status;
    assign rsp.observer_on    = rsp_reg.observer_on;
    assign rsp.status_written = rsp_reg.status_written;

`ifndef SYNTHESIS
    // A rejected or unused command must leave the tracker state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (rsp_next.cmd_status != RES_OK) |=> $stable(state_reg))
        else $error("state changed on a rejected command");

    // A held item may not vanish while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled item lost");

    // The result always reports the status the state holds after the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg && (rsp_reg.host_status == state_reg.status)
                    && (rsp_reg.observer_on == state_reg.observer))
        else $error("result disagrees with committed state");

    // A write of status reports ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status_written |-> rsp_reg.cmd_status == RES_OK)
        else $error("status written on an error result");
`endif

endmodule
